@@ design/rgws_pkg.sv @@
`default_nettype none
package rgws_pkg;

    // global map store
    localparam int MAP_CELLS       = 65536;
    localparam int MAP_AW          = $clog2(MAP_CELLS);

    // local window limits
    localparam int WINDOW_HALF_MAX = 128;
    localparam int HALF_W          = $clog2(WINDOW_HALF_MAX + 1);
    localparam int WIN_W           = HALF_W + 1;
    localparam int RX_W            = HALF_W + 2;

    // arithmetic widths
    localparam int PR_W            = 16 + RX_W;
    localparam int G_W             = 36;
    localparam int MXF_W           = G_W - 14;
    localparam int IDX_W           = 35;

    // item operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_COS_YAW     = 3'd0,
        REG_SIN_YAW     = 3'd1,
        REG_POSE_CELL_X = 3'd2,
        REG_POSE_CELL_Y = 3'd3,
        REG_MAP_COLS    = 3'd4,
        REG_MAP_ROWS    = 3'd5,
        REG_HALF_LONG   = 3'd6,
        REG_HALF_SIDE   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_yaw;
        logic signed [28:0] pose_cell_x;
        logic signed [28:0] pose_cell_y;
        logic [16:0]        map_cols;
        logic [16:0]        map_rows;
        logic [7:0]         half_long;
        logic [7:0]         half_side;
    } cfg_t;

    typedef struct packed {
        logic              op;
        logic [15:0]       store_addr;
        logic signed [7:0] store_value;
        logic [7:0]        local_col;
        logic [7:0]        local_row;
    } item_t;

    typedef struct packed {
        logic signed [7:0] occupancy;
        logic [15:0]       window_index;
        logic              inside_map;
    } result_t;

    // one access to the map store, in item order
    typedef struct packed {
        logic              valid;
        logic              write;
        logic              in_map;
        logic [MAP_AW-1:0] addr;
        logic [7:0]        wdata;
        logic [15:0]       window_index;
    } mem_req_t;

endpackage
`default_nettype wire

@@ design/rgws_cfg_regs.sv @@
`default_nettype none
module rgws_cfg_regs
    import rgws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [28:0] wr_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_yaw     <= 16'sd16384;
            cfg_reg.sin_yaw     <= '0;
            cfg_reg.pose_cell_x <= '0;
            cfg_reg.pose_cell_y <= '0;
            cfg_reg.map_cols    <= 17'd256;
            cfg_reg.map_rows    <= 17'd256;
            cfg_reg.half_long   <= 8'd64;
            cfg_reg.half_side   <= 8'd64;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_COS_YAW:     cfg_reg.cos_yaw     <= wr_data[15:0];
                REG_SIN_YAW:     cfg_reg.sin_yaw     <= wr_data[15:0];
                REG_POSE_CELL_X: cfg_reg.pose_cell_x <= wr_data;
                REG_POSE_CELL_Y: cfg_reg.pose_cell_y <= wr_data;
                REG_MAP_COLS:    cfg_reg.map_cols    <= wr_data[16:0];
                REG_MAP_ROWS:    cfg_reg.map_rows    <= wr_data[16:0];
                REG_HALF_LONG:   cfg_reg.half_long   <= wr_data[7:0];
                REG_HALF_SIDE:   cfg_reg.half_side   <= wr_data[7:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ design/rgws_addr_pipe.sv @@
`default_nettype none
module rgws_addr_pipe
    import rgws_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  item_t      cmd,
    input  cfg_t       cfg,
    output mem_req_t   req
);

    function automatic logic [HALF_W-1:0] clamp_half(input logic [7:0] h);
        logic [HALF_W-1:0] r;
        if (h == 8'd0)
            r = HALF_W'(1);
        else if (32'(h) > WINDOW_HALF_MAX)
            r = HALF_W'(WINDOW_HALF_MAX);
        else
            r = HALF_W'(h);
        return r;
    endfunction

    logic [HALF_W-1:0]      hl;
    logic [HALF_W-1:0]      hs;
    logic [WIN_W-1:0]       win_h;
    logic signed [RX_W-1:0] rx;
    logic signed [RX_W-1:0] ry;

    assign hl    = clamp_half(cfg.half_long);
    assign hs    = clamp_half(cfg.half_side);
    assign win_h = {hl, 1'b0};
    assign rx    = $signed(RX_W'(cmd.local_col)) - $signed(RX_W'(win_h));
    assign ry    = $signed(RX_W'(cmd.local_row)) - $signed(RX_W'(hs));

    // stage 1: captured item and window offset
    logic                   s1_v_reg;
    logic                   s1_op_reg;
    logic [15:0]            s1_addr_reg;
    logic [7:0]             s1_val_reg;
    logic [7:0]             s1_col_reg;
    logic [7:0]             s1_row_reg;
    logic signed [RX_W-1:0] s1_rx_reg;
    logic signed [RX_W-1:0] s1_ry_reg;

    // stage 2: rotation products and window index products
    logic                   s2_v_reg;
    logic                   s2_op_reg;
    logic [15:0]            s2_addr_reg;
    logic [7:0]             s2_val_reg;
    logic [7:0]             s2_col_reg;
    logic signed [PR_W-1:0] s2_cx_reg;
    logic signed [PR_W-1:0] s2_sy_reg;
    logic signed [PR_W-1:0] s2_sx_reg;
    logic signed [PR_W-1:0] s2_cy_reg;
    logic [2*WIN_W-1:0]     s2_wh_reg;
    logic [8+WIN_W-1:0]     s2_rw_reg;

    // stage 3: global point, 14 fraction bits
    logic                   s3_v_reg;
    logic                   s3_op_reg;
    logic [15:0]            s3_addr_reg;
    logic [7:0]             s3_val_reg;
    logic signed [G_W-1:0]  s3_gx_reg;
    logic signed [G_W-1:0]  s3_gy_reg;
    logic [15:0]            s3_widx_reg;

    // stage 4: map cell and bounds
    logic                   s4_v_reg;
    logic                   s4_op_reg;
    logic [15:0]            s4_addr_reg;
    logic [7:0]             s4_val_reg;
    logic                   s4_in_reg;
    logic [16:0]            s4_mx_reg;
    logic [16:0]            s4_my_reg;
    logic [15:0]            s4_widx_reg;

    // stage 5: row offset
    logic                   s5_v_reg;
    logic                   s5_op_reg;
    logic [15:0]            s5_addr_reg;
    logic [7:0]             s5_val_reg;
    logic                   s5_in_reg;
    logic [16:0]            s5_mx_reg;
    logic [33:0]            s5_prod_reg;
    logic [15:0]            s5_widx_reg;

    logic [WIN_W-1:0]       s1_w;
    logic [WIN_W-1:0]       s1_h;
    logic signed [G_W-1:0]  px;
    logic signed [G_W-1:0]  py;
    logic [MXF_W-1:0]       mxf;
    logic [MXF_W-1:0]       myf;
    logic [IDX_W-1:0]       idx;

    assign s1_w = {clamp_half(cfg.half_side), 1'b0};
    assign s1_h = {clamp_half(cfg.half_long), 1'b0};
    assign px   = {cfg.pose_cell_x[28], cfg.pose_cell_x, 6'b0};
    assign py   = {cfg.pose_cell_y[28], cfg.pose_cell_y, 6'b0};
    assign mxf  = s3_gx_reg[G_W-1:14];
    assign myf  = s3_gy_reg[G_W-1:14];
    assign idx  = IDX_W'(s5_prod_reg) + IDX_W'(s5_mx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= cmd.op;
        s1_addr_reg <= cmd.store_addr;
        s1_val_reg  <= cmd.store_value;
        s1_col_reg  <= cmd.local_col;
        s1_row_reg  <= cmd.local_row;
        s1_rx_reg   <= rx;
        s1_ry_reg   <= ry;

        s2_op_reg   <= s1_op_reg;
        s2_addr_reg <= s1_addr_reg;
        s2_val_reg  <= s1_val_reg;
        s2_col_reg  <= s1_col_reg;
        s2_cx_reg   <= $signed(cfg.cos_yaw) * s1_rx_reg;
        s2_sy_reg   <= $signed(cfg.sin_yaw) * s1_ry_reg;
        s2_sx_reg   <= $signed(cfg.sin_yaw) * s1_rx_reg;
        s2_cy_reg   <= $signed(cfg.cos_yaw) * s1_ry_reg;
        s2_wh_reg   <= s1_w * s1_h;
        s2_rw_reg   <= s1_row_reg * s1_w;

        s3_op_reg   <= s2_op_reg;
        s3_addr_reg <= s2_addr_reg;
        s3_val_reg  <= s2_val_reg;
        s3_gx_reg   <= px - (G_W'(s2_cx_reg) - G_W'(s2_sy_reg));
        s3_gy_reg   <= py - (G_W'(s2_sx_reg) + G_W'(s2_cy_reg));
        s3_widx_reg <= 16'(s2_wh_reg) - 16'(s2_rw_reg) - 16'(s2_col_reg) - 16'd1;

        s4_op_reg   <= s3_op_reg;
        s4_addr_reg <= s3_addr_reg;
        s4_val_reg  <= s3_val_reg;
        // negative points are outside, not wrapped
        s4_in_reg   <= !s3_gx_reg[G_W-1] && !s3_gy_reg[G_W-1]
                       && (mxf < MXF_W'(cfg.map_cols))
                       && (myf < MXF_W'(cfg.map_rows));
        s4_mx_reg   <= mxf[16:0];
        s4_my_reg   <= myf[16:0];
        s4_widx_reg <= s3_widx_reg;

        s5_op_reg   <= s4_op_reg;
        s5_addr_reg <= s4_addr_reg;
        s5_val_reg  <= s4_val_reg;
        s5_in_reg   <= s4_in_reg;
        s5_mx_reg   <= s4_mx_reg;
        s5_prod_reg <= s4_my_reg * cfg.map_cols;
        s5_widx_reg <= s4_widx_reg;
    end

    always_comb
    begin
        req.valid        = s5_v_reg;
        req.write        = (s5_op_reg == OP_WRITE);
        req.wdata        = s5_val_reg;
        req.window_index = s5_widx_reg;
        if (s5_op_reg == OP_WRITE)
        begin
            req.in_map = (32'(s5_addr_reg) < MAP_CELLS);
            req.addr   = MAP_AW'(s5_addr_reg);
        end
        else
        begin
            req.in_map = s5_in_reg && (idx < IDX_W'(MAP_CELLS));
            req.addr   = idx[MAP_AW-1:0];
        end
    end

endmodule
`default_nettype wire

@@ design/rgws_map_store.sv @@
`default_nettype none
module rgws_map_store
    import rgws_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  mem_req_t  req,
    output wire logic done,
    output result_t   result
);

    logic [7:0]  mem [MAP_CELLS];

    logic        done_reg;
    logic        in_map_reg;
    logic [15:0] widx_reg;
    logic [7:0]  rdata_reg;

    // single port: one write or one read per cycle, in item order
    always_ff @(posedge clk)
    begin
        if (req.valid && req.write && req.in_map)
            mem[req.addr] <= req.wdata;
        if (req.valid && !req.write && req.in_map)
            rdata_reg <= mem[req.addr];
        in_map_reg <= req.in_map;
        widx_reg   <= req.window_index;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= req.valid && !req.write;
    end

    assign done                = done_reg;
    assign result.occupancy    = in_map_reg ? rdata_reg : 8'hFF;
    assign result.window_index = widx_reg;
    assign result.inside_map   = in_map_reg;

endmodule
`default_nettype wire

@@ design/rotated_grid_window_sampler.sv @@
`default_nettype none
// rotated grid window sampler: holds a global occupancy map and samples it at
// the cells of a robot-centered window turned by the robot yaw. one item is
// taken per clock with no gaps; busy is always low. write items load one map
// cell and give no result; query items give exactly one result: done goes high
// for one cycle once the item has passed the five address stages and the
// registered map read, and the result is valid while done is high. the
// receiver cannot stall, so it must take every result in that cycle. items are
// handled strictly in order, so a query sees every earlier write. the map
// store powers up undefined: query only cells that were written. configuration
// writes go straight to the registers and should only be made when no query
// is in flight.
module rotated_grid_window_sampler
    import rgws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        start,
    output wire logic        busy,
    input  item_t            cmd,
    // result channel
    output wire logic        done,
    output result_t          result,
    // configuration write port
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [28:0] wr_data
);

    cfg_t     cfg;
    mem_req_t req;
    logic     accept;

    // the pipeline never backs up, so every start is a transfer
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    rgws_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // window offset, rotation, bounds and map address, five stages
    rgws_addr_pipe u_addr_pipe (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd),
        .cfg    (cfg),
        .req    (req)
    );

    // map memory, registered read, result formation
    rgws_map_store u_map_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .done   (done),
        .result (result)
    );

endmodule
`default_nettype wire

@@ design/rgws_checker.sv @@
`default_nettype none
module rgws_checker
    import rgws_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input item_t     cmd,
    input wire logic done,
    input result_t   result
);

    // a query transfer always gives a result
    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_QUERY) |-> ##6 done)
        else $error("query gave no result");

    // a write transfer gives no result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_WRITE) |-> ##6 !done)
        else $error("write gave a result");

    // no result without a query transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && cmd.op == OP_QUERY, 6))
        else $error("result without query");

    // points off the map read as unknown
    a_outside_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.inside_map) |-> (result.occupancy == 8'hFF))
        else $error("outside point not unknown");

endmodule

bind rotated_grid_window_sampler rgws_checker u_rgws_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
    import rgws_pkg::*;

    // run limit in clock cycles, far above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;
    // cycles allowed after the last result for write transfers still in flight
    localparam int SETTLE_CYCLES = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    item_t       cmd = '0;
    logic        done;
    result_t     result;
    logic        wr_en = 1'b0;
    logic [2:0]  wr_index = '0;
    logic [28:0] wr_data = '0;

    rotated_grid_window_sampler uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial forever #1 clk = ~clk;

    // items waiting to be offered, and samples waiting to come back
    item_t   pending_items[$];
    result_t expected_samples[$];

    // shadow of the block: its registers and its map store
    cfg_t       shadow_cfg;
    logic [7:0] shadow_map [MAP_CELLS];
    // cells that some queued write has loaded, so queries never read junk
    bit         cell_loaded [MAP_CELLS];

    int mismatches = 0;
    int cycle_count = 0;
    int idle_left = 0;
    bit idle_on = 1'b1;

    // window halves are clamped to 1..WINDOW_HALF_MAX
    function automatic int clamp_half(input logic [7:0] h);
        if (h == 8'd0)
            return 1;
        if (h > WINDOW_HALF_MAX)
            return WINDOW_HALF_MAX;
        return int'(h);
    endfunction

    // turn the window cell by the yaw, subtract it from the pose and find the
    // map cell; returns 0 when the point lands off the map or past the store
    function automatic logic locate_cell(input cfg_t c, input logic [7:0] col,
                                         input logic [7:0] row,
                                         output logic [15:0] map_cell);
        longint rx, ry, gx, gy, mx, my, lin;
        map_cell = '0;
        rx = longint'(col) - 2 * clamp_half(c.half_long);
        ry = longint'(row) - clamp_half(c.half_side);
        // 14 fraction bits throughout, exact
        gx = longint'($signed(c.pose_cell_x)) * 64
             - (longint'($signed(c.cos_yaw)) * rx - longint'($signed(c.sin_yaw)) * ry);
        gy = longint'($signed(c.pose_cell_y)) * 64
             - (longint'($signed(c.sin_yaw)) * rx + longint'($signed(c.cos_yaw)) * ry);
        // negative coordinates are off the map, no wrap
        if (gx < 0 || gy < 0)
            return 1'b0;
        mx = gx >>> 14;
        my = gy >>> 14;
        // over-width or over-height, also catches a zero-sized map
        if (mx >= longint'(c.map_cols) || my >= longint'(c.map_rows))
            return 1'b0;
        lin = my * longint'(c.map_cols) + mx;
        // linear index past the end of the store
        if (lin >= MAP_CELLS)
            return 1'b0;
        map_cell = 16'(lin);
        return 1'b1;
    endfunction

    // item driver: offers queued items, models each transfer as it happens
    always @(posedge clk or negedge rst_n) begin : item_driver
        logic       hit;
        logic [15:0] map_cell;
        longint     w, hgt, flipped;
        result_t    sample;
        if (!rst_n) begin
            start <= 1'b0;
            cmd <= '0;
            idle_left = 0;
        end
        else begin
            // transfer at this edge: update the shadow map or predict a sample
            if (start && !busy) begin
                if (cmd.op == OP_WRITE) begin
                    shadow_map[cmd.store_addr] = cmd.store_value;
                end
                else begin
                    hit = locate_cell(shadow_cfg, cmd.local_col, cmd.local_row, map_cell);
                    w = 2 * clamp_half(shadow_cfg.half_side);
                    hgt = 2 * clamp_half(shadow_cfg.half_long);
                    // flipped index, wraps mod 2^16 for cells outside the window
                    flipped = w * hgt - (longint'(cmd.local_row) * w
                              + longint'(cmd.local_col)) - 1;
                    sample.occupancy = hit ? shadow_map[map_cell] : 8'hFF;
                    sample.window_index = 16'(flipped);
                    sample.inside_map = hit;
                    expected_samples.insert(expected_samples.size(), sample);
                end
            end
            // while held off keep the same item on the port
            if (!(start && busy)) begin
                if (idle_left > 0) begin
                    start <= 1'b0;
                    idle_left--;
                end
                else if (pending_items.size() != 0) begin
                    cmd <= pending_items.pop_front();
                    start <= 1'b1;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        idle_left = $urandom_range(1, 15);
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // sample monitor: every strobed result is compared with the oldest prediction
    always @(posedge clk) begin : sample_monitor
        result_t want;
        if (rst_n && done) begin
            if (expected_samples.size() == 0) begin
                $display("%0t ns: expected no result, got occupancy %0d index %0d inside %0b",
                         $time, result.occupancy, result.window_index, result.inside_map);
                mismatches++;
            end
            else begin
                want = expected_samples.pop_front();
                if (result.occupancy !== want.occupancy) begin
                    $display("%0t ns: occupancy expected %0d, got %0d",
                             $time, want.occupancy, result.occupancy);
                    mismatches++;
                end
                if (result.window_index !== want.window_index) begin
                    $display("%0t ns: window_index expected %0d, got %0d",
                             $time, want.window_index, result.window_index);
                    mismatches++;
                end
                if (result.inside_map !== want.inside_map) begin
                    $display("%0t ns: inside_map expected %0b, got %0b",
                             $time, want.inside_map, result.inside_map);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d samples still outstanding",
                     $time, expected_samples.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_write(input logic [15:0] addr, input logic [7:0] value);
        item_t it;
        it.op = OP_WRITE;
        it.store_addr = addr;
        it.store_value = value;
        // unused on a write, toggled anyway
        it.local_col = 8'($urandom);
        it.local_row = 8'($urandom);
        cell_loaded[addr] = 1'b1;
        pending_items.insert(pending_items.size(), it);
    endtask

    // a query that would land on a never-loaded cell gets a write in front of it
    task automatic queue_query(input logic [7:0] col, input logic [7:0] row);
        item_t       it;
        logic        hit;
        logic [15:0] map_cell;
        hit = locate_cell(shadow_cfg, col, row, map_cell);
        if (hit && !cell_loaded[map_cell])
            queue_write(map_cell, 8'($urandom));
        it.op = OP_QUERY;
        it.store_addr = 16'($urandom);
        it.store_value = 8'($urandom);
        it.local_col = col;
        it.local_row = row;
        pending_items.insert(pending_items.size(), it);
    endtask

    // mostly queries inside the window, some anywhere, plus writes over the map;
    // count covers the loading writes put in front of queries as well
    task automatic fill_phase(input int count);
        int     hl, hs, limit, base;
        longint span;
        hl = clamp_half(shadow_cfg.half_long);
        hs = clamp_half(shadow_cfg.half_side);
        span = longint'(shadow_cfg.map_cols) * longint'(shadow_cfg.map_rows);
        limit = (span > MAP_CELLS) ? MAP_CELLS : int'(span);
        base = pending_items.size();
        while (pending_items.size() < base + count) begin
            if ($urandom_range(0, 99) < 75) begin
                if ($urandom_range(0, 9) != 0)
                    queue_query(8'($urandom_range(0, 2 * hs - 1)),
                                8'($urandom_range(0, 2 * hl - 1)));
                else
                    queue_query(8'($urandom), 8'($urandom));
            end
            else if (limit > 0 && $urandom_range(0, 4) != 0) begin
                queue_write(16'($urandom_range(0, limit - 1)), 8'($urandom));
            end
            else begin
                queue_write(16'($urandom), 8'($urandom));
            end
        end
    endtask

    // sender holds off until every sample is back and writes have drained
    task automatic wait_idle();
        while (pending_items.size() != 0 || start || expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all eight registers, one per edge, only while the block is quiet
    task automatic load_setting(input cfg_t c);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= REG_COS_YAW;
        wr_data <= {{13{c.cos_yaw[15]}}, c.cos_yaw};
        @(posedge clk);
        wr_index <= REG_SIN_YAW;
        wr_data <= {{13{c.sin_yaw[15]}}, c.sin_yaw};
        @(posedge clk);
        wr_index <= REG_POSE_CELL_X;
        wr_data <= c.pose_cell_x;
        @(posedge clk);
        wr_index <= REG_POSE_CELL_Y;
        wr_data <= c.pose_cell_y;
        @(posedge clk);
        wr_index <= REG_MAP_COLS;
        wr_data <= {12'd0, c.map_cols};
        @(posedge clk);
        wr_index <= REG_MAP_ROWS;
        wr_data <= {12'd0, c.map_rows};
        @(posedge clk);
        wr_index <= REG_HALF_LONG;
        wr_data <= {21'd0, c.half_long};
        @(posedge clk);
        wr_index <= REG_HALF_SIDE;
        wr_data <= {21'd0, c.half_side};
        @(posedge clk);
        wr_en <= 1'b0;
        shadow_cfg = c;
    endtask

    initial begin : sequencer
        cfg_t c;
        real  yaw;
        // register values right after reset
        shadow_cfg.cos_yaw = 16'sd16384;
        shadow_cfg.sin_yaw = 16'sd0;
        shadow_cfg.pose_cell_x = '0;
        shadow_cfg.pose_cell_y = '0;
        shadow_cfg.map_cols = 17'd256;
        shadow_cfg.map_rows = 17'd256;
        shadow_cfg.half_long = 8'd64;
        shadow_cfg.half_side = 8'd64;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the reset setting: the pose sits on the map corner,
        // so window column 128 / row 64 lands on map cell (0,0)
        queue_write(16'h0000, 8'h80);
        queue_write(16'hFFFF, 8'h7F);
        queue_write(16'h5555, 8'd100);
        queue_write(16'hAAAA, 8'h00);
        queue_write(16'h8000, 8'hFF);
        queue_query(8'd128, 8'd64);
        queue_query(8'd0, 8'd0);
        queue_query(8'd128, 8'd0);
        queue_query(8'd0, 8'd64);
        // overwrite then read back straight away
        queue_write(16'h0000, 8'd100);
        queue_query(8'd128, 8'd64);
        // one step past the corner, negative x then negative y
        queue_query(8'd129, 8'd64);
        queue_query(8'd128, 8'd65);
        // far corners of the field range, outside the window too
        queue_query(8'd255, 8'd255);
        queue_query(8'd0, 8'd255);
        queue_query(8'd255, 8'd0);
        queue_query(8'd127, 8'd63);
        queue_query(8'd64, 8'd32);
        wait_idle();

        for (int p = 1; p <= 12; p++) begin
            // a plausible setting: unit rotation, pose on or near the map
            yaw = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
            c.cos_yaw = 16'($rtoi($cos(yaw) * 16384.0));
            c.sin_yaw = 16'($rtoi($sin(yaw) * 16384.0));
            c.map_cols = 17'($urandom_range(8, 300));
            c.map_rows = 17'($urandom_range(8, 300));
            c.half_long = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 128))
                                                       : 8'($urandom_range(1, 16));
            c.half_side = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(17, 128))
                                                       : 8'($urandom_range(1, 16));
            // a few cells of margin around the map hit both edges
            c.pose_cell_x = 29'(int'($urandom_range(0, (int'(c.map_cols) + 8) * 256)) - 1024);
            c.pose_cell_y = 29'(int'($urandom_range(0, (int'(c.map_rows) + 8) * 256)) - 1024);
            case (p)
                1: begin
                    // zero-width map, nothing is inside
                    c.map_cols = 17'd0;
                end
                2: begin
                    // map larger than the store, full-size window
                    c.map_cols = 17'd65536;
                    c.map_rows = 17'd65536;
                    c.half_long = 8'd128;
                    c.half_side = 8'd128;
                    c.pose_cell_x = 29'(300 * 256);
                    c.pose_cell_y = 29'($urandom_range(0, 4 * 256));
                end
                3: begin
                    // extreme registers, window halves clamped at both ends
                    c.cos_yaw = 16'sh8000;
                    c.sin_yaw = 16'sh7FFF;
                    c.pose_cell_x = 29'h1000_0000;
                    c.pose_cell_y = 29'h0FFF_FFFF;
                    c.half_long = 8'd0;
                    c.half_side = 8'd255;
                end
                4: begin
                    // single-cell map, smallest window
                    c.cos_yaw = 16'sd16384;
                    c.sin_yaw = 16'sd0;
                    c.map_cols = 17'd1;
                    c.map_rows = 17'd1;
                    c.half_long = 8'd1;
                    c.half_side = 8'd1;
                    c.pose_cell_x = 29'(-2 * 256 - 128);
                    c.pose_cell_y = 29'd64;
                end
                5: begin
                    // widest map, one row: indexes run past the store
                    c.map_cols = 17'h1FFFF;
                    c.map_rows = 17'd1;
                    c.pose_cell_x = 29'($urandom_range(60000, 70000) * 256);
                    c.pose_cell_y = 29'd128;
                end
                6: begin
                    // off-unit rotation at the nominal extremes
                    c.cos_yaw = 16'sd16384;
                    c.sin_yaw = -16'sd16384;
                end
                7: begin
                    c.cos_yaw = -16'sd16384;
                    c.sin_yaw = 16'sd0;
                end
                8: begin
                    // arbitrary register contents
                    c.cos_yaw = 16'($urandom);
                    c.sin_yaw = 16'($urandom);
                end
                default: ;
            endcase
            load_setting(c);
            // some phases with no idle at all, the last one among them
            idle_on = (p % 3 != 0);
            fill_phase(150);
            wait_idle();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
